// ===== design/ftm_pkg.sv =====
// Package for the fork token mutex agent: sizes, event and message codes,
// fork bit positions, sequencer states and the reset rule for a fork entry.
// Depends on nothing; imported by fork_token_mutex_agent_top.
package ftm_pkg;

  localparam int unsigned MAX_PEERS  = 16;
  localparam int unsigned ID_W       = $clog2(MAX_PEERS);
  localparam int unsigned COUNT_W    = ID_W + 1;
  localparam int unsigned FORK_W     = 3;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned MSG_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Bit positions inside one fork entry.
  localparam int unsigned FB_PRESENT = 0;
  localparam int unsigned FB_DIRTY   = 1;
  localparam int unsigned FB_TOKEN   = 2;

  typedef logic [ID_W-1:0]   peer_id_t;
  typedef logic [FORK_W-1:0] fork_t;

  localparam logic [FUNC_W-1:0] FUNC_REQ_ENTRY = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MSG       = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE   = 2'd2;

  localparam logic [MSG_W-1:0] MSG_FORK_REQ   = 2'd0;
  localparam logic [MSG_W-1:0] MSG_FORK_REPLY = 2'd1;
  localparam logic [MSG_W-1:0] MSG_PEER_DONE  = 2'd2;

  localparam logic SEND_FORK_REQ   = 1'b0;
  localparam logic SEND_FORK_REPLY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MSG,
    ST_MSG2,
    ST_WALK
  } state_t;

  typedef enum logic [1:0] {
    WALK_REQ,
    WALK_REL,
    WALK_CHECK
  } walk_t;

  // Initial fork assignment: the lower id holds a dirty fork, the other
  // side holds the request token.
  function automatic fork_t init_fork(peer_id_t self_id, peer_id_t idx);
    fork_t f;
    f = '0;
    if (self_id < idx) begin
      f[FB_PRESENT] = 1'b1;
      f[FB_DIRTY]   = 1'b1;
    end else begin
      f[FB_TOKEN] = 1'b1;
    end
    return f;
  endfunction

endpackage

// ===== design/fork_token_mutex_agent_top.sv =====
// Top level of the fork token mutex agent: one node of a fork based
// distributed mutual exclusion scheme, fork state held in a small memory.
// Depends on ftm_pkg.
// Usage. An event is transferred in at a rising edge where start is high
// and busy is low: in_func selects request entry, message arrived or
// release; in_msg_kind and in_src_peer describe an arrived message.
// Each event produces zero or more message results followed by exactly one
// status result, each on the out_ ports for one cycle, marked by out_valid;
// out_last marks the status, whose out_granted says whether every active
// peer's fork is held and clean. The receiver cannot stall the block.
// Walk. Every event walks the fork memory once, one entry per cycle,
// behind a registered read, over ids 1 to n - 1, n being peer_count
// limited to 16. A fork request or reply adds the read-modify-write state
// ST_MSG before the walk, followed by ST_MSG2 when two messages go out.
// One event is in flight at a time; a new one may be transferred in the
// cycle the status shows, so the memory read port sets the rate.
// Configuration. The cfg_ port writes self_id (index 0) or peer_count
// (index 1) while busy is low; either write, like reset (self_id 1,
// peer_count 2), restores the initial fork assignment and clears every
// finished mark. Per-entry valid bits make a clearing pass unnecessary.
module fork_token_mutex_agent_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ftm_pkg::FUNC_W-1:0] in_func,
  input  logic [ftm_pkg::MSG_W-1:0]  in_msg_kind,
  input  logic [ftm_pkg::ID_W-1:0]   in_src_peer,
  output logic                       out_valid,
  output logic                       out_send_valid,
  output logic [ftm_pkg::ID_W-1:0]   out_dest_peer,
  output logic                       out_send_kind,
  output logic                       out_granted,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ftm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ftm_pkg::*;

  // Control state.
  state_t               state_r, state_nxt;
  walk_t                mode_r, mode_nxt;
  logic [MSG_W-1:0]     kind_r, kind_nxt;
  logic [COUNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                 p_vld_r, p_vld_nxt;
  logic                 grant_r, grant_nxt;
  peer_id_t             p_idx_r;

  // Configuration registers.
  peer_id_t             self_id_r;
  logic [COUNT_W-1:0]   peer_count_r;

  // Fork memory with per-entry valid bits, and finished marks.
  fork_t                fork_mem [MAX_PEERS];
  fork_t                rd_data_r;
  logic                 rd_hit_r;
  logic [MAX_PEERS-1:0] valid_r;
  logic [MAX_PEERS-1:0] fin_r;

  // Output register.
  logic                 out_valid_r;
  logic                 out_send_r, out_kind_r, out_grant_r, out_last_r;
  peer_id_t             out_dest_r;

  // Combinational controls.
  peer_id_t             rd_addr;
  logic                 mem_we;
  fork_t                mem_wdata;
  logic                 fin_set;
  logic                 emit;
  logic                 e_send, e_kind, e_grant, e_last;
  peer_id_t             e_dest;
  logic [COUNT_W-1:0]   n_lim;
  fork_t                cur;
  fork_t                upd;
  logic                 active;
  logic                 src_ok;
  logic                 issue;
  logic                 accept;
  logic                 cfg_wr;
  logic                 cfg_reinit;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign accept    = start && (state_r == ST_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_reinit = cfg_wr &&
                      ((cfg_index == CFG_SELF_ID) || (cfg_index == CFG_PEER_COUNT));

  // Ids in use are limited to the size of the fork memory.
  assign n_lim = (peer_count_r > COUNT_W'(MAX_PEERS)) ? COUNT_W'(MAX_PEERS)
                                                      : peer_count_r;

  // An entry never written since reset or reconfiguration reads as its
  // initial assignment.
  assign cur    = rd_hit_r ? rd_data_r : init_fork(self_id_r, p_idx_r);
  assign active = (p_idx_r != self_id_r) && !fin_r[p_idx_r];
  assign src_ok = (in_src_peer != '0) && (in_src_peer != self_id_r) &&
                  ({1'b0, in_src_peer} < n_lim);
  assign issue  = (rd_idx_r < n_lim);

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    kind_nxt   = kind_r;
    rd_idx_nxt = rd_idx_r;
    p_vld_nxt  = 1'b0;
    grant_nxt  = grant_r;
    rd_addr    = p_idx_r;
    mem_we     = 1'b0;
    mem_wdata  = cur;
    fin_set    = 1'b0;
    emit       = 1'b0;
    e_send     = 1'b0;
    e_dest     = '0;
    e_kind     = SEND_FORK_REQ;
    e_grant    = 1'b0;
    e_last     = 1'b0;
    upd        = cur;

    case (state_r)
      ST_IDLE: begin
        rd_addr = in_src_peer;
        if (accept) begin
          rd_idx_nxt = COUNT_W'(1);
          grant_nxt  = 1'b1;
          kind_nxt   = in_msg_kind;
          state_nxt  = ST_WALK;
          mode_nxt   = WALK_CHECK;
          case (in_func)
            FUNC_REQ_ENTRY: mode_nxt = WALK_REQ;
            FUNC_RELEASE:   mode_nxt = WALK_REL;
            FUNC_MSG: begin
              if (src_ok && (in_msg_kind inside {MSG_FORK_REQ, MSG_FORK_REPLY})) begin
                state_nxt = ST_MSG;
              end else if (src_ok && (in_msg_kind == MSG_PEER_DONE)) begin
                fin_set = 1'b1;
              end
            end
            default: mode_nxt = WALK_CHECK;
          endcase
        end
      end

      // Read data of the sending peer's entry is ready: modify and write back.
      ST_MSG: begin
        mem_we    = 1'b1;
        mode_nxt  = WALK_CHECK;
        state_nxt = ST_WALK;
        if (kind_r == MSG_FORK_REPLY) begin
          upd[FB_PRESENT] = 1'b1;
          upd[FB_DIRTY]   = 1'b0;
          mem_wdata       = upd;
        end else begin
          upd[FB_TOKEN] = 1'b1;
          if (cur[FB_PRESENT] && cur[FB_DIRTY]) begin
            // A dirty fork is given up together with the token.
            mem_wdata = '0;
            emit      = 1'b1;
            e_send    = 1'b1;
            e_dest    = p_idx_r;
            e_kind    = SEND_FORK_REPLY;
            state_nxt = ST_MSG2;
          end else begin
            mem_wdata = upd;
          end
        end
      end

      // Ask for the fork straight back after handing it over.
      ST_MSG2: begin
        emit      = 1'b1;
        e_send    = 1'b1;
        e_dest    = p_idx_r;
        e_kind    = SEND_FORK_REQ;
        state_nxt = ST_WALK;
      end

      // One entry is read per cycle; the entry read last cycle is processed.
      ST_WALK: begin
        rd_addr = rd_idx_r[ID_W-1:0];
        if (issue) begin
          rd_idx_nxt = rd_idx_r + COUNT_W'(1);
          p_vld_nxt  = 1'b1;
        end
        if (p_vld_r && active) begin
          case (mode_r)
            WALK_REQ: begin
              if (!cur[FB_PRESENT] && cur[FB_TOKEN]) begin
                upd[FB_TOKEN] = 1'b0;
                emit   = 1'b1;
                e_send = 1'b1;
                e_dest = p_idx_r;
                e_kind = SEND_FORK_REQ;
              end
              mem_we    = 1'b1;
              mem_wdata = upd;
            end
            WALK_REL: begin
              if (cur[FB_PRESENT]) begin
                if (cur[FB_TOKEN]) begin
                  upd    = '0;
                  upd[FB_TOKEN] = 1'b1;
                  emit   = 1'b1;
                  e_send = 1'b1;
                  e_dest = p_idx_r;
                  e_kind = SEND_FORK_REPLY;
                end else begin
                  upd[FB_DIRTY] = 1'b1;
                end
              end
              mem_we    = 1'b1;
              mem_wdata = upd;
            end
            default: upd = cur;
          endcase
          if (!upd[FB_PRESENT] || upd[FB_DIRTY]) begin
            grant_nxt = 1'b0;
          end
        end
        if (!p_vld_r && !issue) begin
          emit      = 1'b1;
          e_grant   = grant_r;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= WALK_CHECK;
      kind_r      <= MSG_FORK_REQ;
      rd_idx_r    <= '0;
      p_vld_r     <= 1'b0;
      grant_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      kind_r      <= kind_nxt;
      rd_idx_r    <= rd_idx_nxt;
      p_vld_r     <= p_vld_nxt;
      grant_r     <= grant_nxt;
      out_valid_r <= emit;
    end
  end

  // Configuration registers, valid bits and finished marks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r    <= ID_W'(1);
      peer_count_r <= COUNT_W'(2);
      valid_r      <= '0;
      fin_r        <= '0;
    end else begin
      if (cfg_wr && (cfg_index == CFG_SELF_ID)) begin
        self_id_r <= cfg_data[ID_W-1:0];
      end
      if (cfg_wr && (cfg_index == CFG_PEER_COUNT)) begin
        peer_count_r <= cfg_data[COUNT_W-1:0];
      end
      if (cfg_reinit) begin
        valid_r <= '0;
        fin_r   <= '0;
      end else begin
        if (mem_we) begin
          valid_r[p_idx_r] <= 1'b1;
        end
        if (fin_set) begin
          fin_r[in_src_peer] <= 1'b1;
        end
      end
    end
  end

  // Fork memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fork_mem[p_idx_r] <= mem_wdata;
    end
    rd_data_r <= fork_mem[rd_addr];
    rd_hit_r  <= valid_r[rd_addr] && !cfg_reinit;
    p_idx_r   <= rd_addr;
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_send_r  <= e_send;
      out_dest_r  <= e_dest;
      out_kind_r  <= e_kind;
      out_grant_r <= e_grant;
      out_last_r  <= e_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_send_valid = out_send_r;
  assign out_dest_peer  = out_dest_r;
  assign out_send_kind  = out_kind_r;
  assign out_granted    = out_grant_r;
  assign out_last       = out_last_r;

`ifndef ASSERT_OFF
  // The status result is never a message.
  a_status_not_msg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_send_valid)
    else $error("status result carries a message");

  // Leaving the walk always delivers the status result next cycle.
  a_walk_ends_in_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) && (state_nxt == ST_IDLE) |=> out_valid && out_last)
    else $error("walk finished without a status result");

  // The fork memory is only written while an event is in progress.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("fork memory written while idle");

  // Read data is only consumed inside a walk.
  a_proc_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (state_r == ST_WALK))
    else $error("walk read data pending outside the walk");

  // Configuration is never taken while an event is in flight.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |-> !busy && !p_vld_r)
    else $error("configuration write during an event");
`endif

endmodule
